FILE: sv/urde_pkg.sv
// ----------------------------------------------------------------------------
// urde_pkg
// Shared types, codes and the CRC-8 step for the register datagram engine.
// ----------------------------------------------------------------------------
`default_nettype none

package urde_pkg;

   localparam logic [7:0] SYNC_BYTE   = 8'h05;
   localparam logic [7:0] MASTER_ADDR = 8'hFF;
   localparam logic [7:0] CRC_POLY    = 8'h07;
   localparam logic       WRITE_FLAG  = 1'b1;

   localparam logic [3:0] ECHO_READ   = 4'd4;
   localparam logic [3:0] ECHO_WRITE  = 4'd8;
   localparam logic [3:0] REPLY_SYNC  = 4'd4;
   localparam logic [3:0] REPLY_ADDR  = 4'd5;
   localparam logic [3:0] REPLY_REG   = 4'd6;
   localparam logic [3:0] REPLY_LAST  = 4'd11;

   localparam logic [2:0] WRITE_LAST_IDX = 3'd7;
   localparam logic [2:0] READ_LAST_IDX  = 3'd3;

   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_RX    = 2'd2;

   localparam logic OUT_TX    = 1'b0;
   localparam logic OUT_REPLY = 1'b1;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_RX    = 2'd2
   } cmd_kind_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_WECHO = 2'd1,
      PH_READ  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_SYNC   = 3'd1,
      ST_BAD_MASTER = 3'd2,
      ST_BAD_REG    = 3'd3,
      ST_CRC        = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [6:0]  reg_id;
      logic [31:0] write_data;
      logic [7:0]  rx_byte;
   } req_item_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  tx_byte;
      logic        last_byte;
      logic [2:0]  status;
      logic [31:0] read_value;
      logic        crc_error_flag;
   } rsp_item_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [6:0]   reg_id;
      logic [31:0]  write_data;
      logic [7:0]   rx_byte;
   } cmd_type;

   function automatic logic [7:0] crc8_feed(input logic [7:0] crc_i, input logic [7:0] b_i);
      logic [7:0] c;
      logic [7:0] b;
      logic       fb;
      c = crc_i;
      b = b_i;
      for (int k = 0; k < 8; k++) begin
         fb = c[7] ^ b[0];
         c  = {c[6:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
         b = {1'b0, b[7:1]};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: sv/urde_front.sv
// ----------------------------------------------------------------------------
// urde_front
// Classifies input items into commands, queues them, drops unknown types.
// ----------------------------------------------------------------------------
`default_nettype none

module urde_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire urde_pkg::req_item_type req_data,
   output logic                       cmd_valid,
   output urde_pkg::cmd_type          cmd_head,
   input  wire logic                  cmd_pop
);

   localparam int PTR_W = $clog2(urde_pkg::CMD_DEPTH);
   localparam int CNT_W = $clog2(urde_pkg::CMD_DEPTH + 1);

   urde_pkg::cmd_type   mem_ff [urde_pkg::CMD_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   urde_pkg::cmd_type   cmd_new;
   logic                keep;
   logic                do_wr;
   logic                do_rd;

   always_comb begin
      keep              = 1'b1;
      cmd_new.kind      = urde_pkg::CMD_RX;
      cmd_new.reg_id    = req_data.reg_id;
      cmd_new.write_data = req_data.write_data;
      cmd_new.rx_byte   = req_data.rx_byte;
      case (req_data.req_type)
         urde_pkg::REQ_WRITE: cmd_new.kind = urde_pkg::CMD_WRITE;
         urde_pkg::REQ_READ:  cmd_new.kind = urde_pkg::CMD_READ;
         urde_pkg::REQ_RX:    cmd_new.kind = urde_pkg::CMD_RX;
         default:             keep = 1'b0;
      endcase
   end

   assign full      = (count_ff == CNT_W'(urde_pkg::CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_head  = mem_ff[rd_ptr_ff];
   assign do_wr     = push && !full && keep;
   assign do_rd     = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

FILE: sv/urde_rsp_queue.sv
// ----------------------------------------------------------------------------
// urde_rsp_queue
// Result queue between the executor and the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module urde_rsp_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   wr_en,
   input  wire urde_pkg::rsp_item_type wr_data,
   output logic                        q_full,
   output logic                        empty,
   output urde_pkg::rsp_item_type      rsp_data,
   input  wire logic                   pop
);

   localparam int PTR_W = $clog2(urde_pkg::RSP_DEPTH);
   localparam int CNT_W = $clog2(urde_pkg::RSP_DEPTH + 1);

   urde_pkg::rsp_item_type mem_ff [urde_pkg::RSP_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_wr;
   logic                   do_rd;

   assign q_full   = (count_ff == CNT_W'(urde_pkg::RSP_DEPTH));
   assign empty    = (count_ff == '0);
   assign rsp_data = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !q_full;
   assign do_rd    = pop && !empty;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

FILE: sv/urde_exec.sv
// ----------------------------------------------------------------------------
// urde_exec
// Executes queued commands: serializes request datagrams with CRC-8 and
// tracks echo and reply reception.
// ----------------------------------------------------------------------------
`default_nettype none

module urde_exec (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              valid,
   output logic                   ready,
   input  wire logic [7:0]        csr_wdata,
   input  wire logic              cmd_valid,
   input  wire urde_pkg::cmd_type cmd_head,
   output logic                   cmd_pop,
   input  wire logic              rsp_full,
   output logic                   rsp_push,
   output urde_pkg::rsp_item_type rsp_item
);

   logic [7:0]            node_ff;
   logic [2:0]            idx_ff, idx_in;
   logic [7:0]            tcrc_ff, tcrc_in;
   urde_pkg::phase_type   phase_ff, phase_in;
   logic [3:0]            count_ff, count_in;
   logic [7:0]            rcrc_ff, rcrc_in;
   logic [6:0]            pend_ff, pend_in;
   logic [31:0]           value_ff, value_in;
   urde_pkg::status_type  ferr_ff, ferr_in;
   logic                  sticky_ff, sticky_in;
   logic                  is_write;
   logic                  is_last;
   logic [7:0]            tx_sel;
   logic [7:0]            rx;

   assign ready    = 1'b1;
   assign is_write = (cmd_head.kind == urde_pkg::CMD_WRITE);
   assign is_last  = is_write ? (idx_ff == urde_pkg::WRITE_LAST_IDX)
                              : (idx_ff == urde_pkg::READ_LAST_IDX);
   assign rx       = cmd_head.rx_byte;

   always_comb begin
      tx_sel = tcrc_ff;
      if (!is_last) begin
         case (idx_ff)
            3'd0:    tx_sel = urde_pkg::SYNC_BYTE;
            3'd1:    tx_sel = node_ff;
            3'd2:    tx_sel = {is_write & urde_pkg::WRITE_FLAG, cmd_head.reg_id};
            3'd3:    tx_sel = cmd_head.write_data[31:24];
            3'd4:    tx_sel = cmd_head.write_data[23:16];
            3'd5:    tx_sel = cmd_head.write_data[15:8];
            3'd6:    tx_sel = cmd_head.write_data[7:0];
            default: tx_sel = tcrc_ff;
         endcase
      end
   end

   always_comb begin
      idx_in    = idx_ff;
      tcrc_in   = tcrc_ff;
      phase_in  = phase_ff;
      count_in  = count_ff;
      rcrc_in   = rcrc_ff;
      pend_in   = pend_ff;
      value_in  = value_ff;
      ferr_in   = ferr_ff;
      sticky_in = sticky_ff;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      rsp_item  = '0;
      if (cmd_valid && !rsp_full) begin
         case (cmd_head.kind)
            urde_pkg::CMD_WRITE, urde_pkg::CMD_READ: begin
               rsp_push                = 1'b1;
               rsp_item.out_kind       = urde_pkg::OUT_TX;
               rsp_item.tx_byte        = tx_sel;
               rsp_item.last_byte      = is_last;
               rsp_item.crc_error_flag = sticky_ff;
               if (is_last) begin
                  cmd_pop  = 1'b1;
                  idx_in   = '0;
                  tcrc_in  = '0;
                  phase_in = is_write ? urde_pkg::PH_WECHO : urde_pkg::PH_READ;
                  count_in = '0;
                  rcrc_in  = '0;
                  value_in = '0;
                  ferr_in  = urde_pkg::ST_OK;
                  pend_in  = cmd_head.reg_id;
               end else begin
                  idx_in  = idx_ff + 3'd1;
                  tcrc_in = urde_pkg::crc8_feed(tcrc_ff, tx_sel);
               end
            end
            urde_pkg::CMD_RX: begin
               cmd_pop = 1'b1;
               case (phase_ff)
                  urde_pkg::PH_WECHO: begin
                     count_in = count_ff + 4'd1;
                     if (count_in >= urde_pkg::ECHO_WRITE) begin
                        phase_in = urde_pkg::PH_IDLE;
                        count_in = '0;
                     end
                  end
                  urde_pkg::PH_READ: begin
                     if (count_ff < urde_pkg::ECHO_READ) begin
                        count_in = count_ff + 4'd1;
                     end else if (count_ff < urde_pkg::REPLY_LAST) begin
                        if (ferr_ff == urde_pkg::ST_OK) begin
                           if (count_ff == urde_pkg::REPLY_SYNC && rx != urde_pkg::SYNC_BYTE) begin
                              ferr_in = urde_pkg::ST_BAD_SYNC;
                           end
                           if (count_ff == urde_pkg::REPLY_ADDR &&
                               rx != urde_pkg::MASTER_ADDR) begin
                              ferr_in = urde_pkg::ST_BAD_MASTER;
                           end
                           if (count_ff == urde_pkg::REPLY_REG && rx != {1'b0, pend_ff}) begin
                              ferr_in = urde_pkg::ST_BAD_REG;
                           end
                        end
                        if (count_ff > urde_pkg::REPLY_REG) begin
                           value_in = {value_ff[23:0], rx};
                        end
                        rcrc_in  = urde_pkg::crc8_feed(rcrc_ff, rx);
                        count_in = count_ff + 4'd1;
                     end else begin
                        rsp_push          = 1'b1;
                        rsp_item.out_kind = urde_pkg::OUT_REPLY;
                        rsp_item.status   = ferr_ff;
                        if (ferr_ff == urde_pkg::ST_OK) begin
                           if (rx != rcrc_ff) begin
                              rsp_item.status = urde_pkg::ST_CRC;
                              sticky_in       = 1'b1;
                           end else begin
                              sticky_in           = 1'b0;
                              rsp_item.read_value = value_ff;
                           end
                        end
                        rsp_item.crc_error_flag = sticky_in;
                        phase_in = urde_pkg::PH_IDLE;
                        count_in = '0;
                        rcrc_in  = '0;
                        value_in = '0;
                        ferr_in  = urde_pkg::ST_OK;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
            default: begin
               cmd_pop = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff   <= '0;
         idx_ff    <= '0;
         tcrc_ff   <= '0;
         phase_ff  <= urde_pkg::PH_IDLE;
         count_ff  <= '0;
         rcrc_ff   <= '0;
         pend_ff   <= '0;
         value_ff  <= '0;
         ferr_ff   <= urde_pkg::ST_OK;
         sticky_ff <= 1'b0;
      end else begin
         if (valid) begin
            node_ff <= csr_wdata;
         end
         idx_ff    <= idx_in;
         tcrc_ff   <= tcrc_in;
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         rcrc_ff   <= rcrc_in;
         pend_ff   <= pend_in;
         value_ff  <= value_in;
         ferr_ff   <= ferr_in;
         sticky_ff <= sticky_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/uart_register_datagram_engine_core.sv
// ----------------------------------------------------------------------------
// uart_register_datagram_engine_core
// Items are registered in the command queue, their results in the result queue.
// The executor emits one datagram byte per cycle while the result queue has room:
// 8 bytes for a write request, 4 for a read; line bytes are consumed the same way.
// Reset: synchronous; empties both queues, returns to idle, clears node address,
// reception state and the sticky CRC error flag.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_register_datagram_engine_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   output logic                        full,
   input  wire urde_pkg::req_item_type req_data,
   output logic                        empty,
   input  wire logic                   pop,
   output urde_pkg::rsp_item_type      rsp_data,
   input  wire logic                   valid,
   output logic                        ready,
   input  wire logic [7:0]             csr_wdata
);

   logic                   cmd_valid;
   urde_pkg::cmd_type      cmd_head;
   logic                   cmd_pop;
   logic                   rsp_full;
   logic                   rsp_push;
   urde_pkg::rsp_item_type rsp_item;

   urde_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop)
   );

   urde_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .valid     (valid),
      .ready     (ready),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_item)
   );

   urde_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (rsp_push),
      .wr_data  (rsp_item),
      .q_full   (rsp_full),
      .empty    (empty),
      .rsp_data (rsp_data),
      .pop      (pop)
   );

endmodule

`default_nettype wire
